// ----- sv/eac_pkg.sv -----
// shared types and constants for the encoder angle conditioner
`default_nettype none

package eac_pkg;

	// angle format: one turn is 2^ANGLE_BITS counts, FRAC_BITS fraction bits below
	localparam int ANGLE_BITS = 14;
	localparam int FRAC_BITS  = 10;
	localparam int FX_BITS    = ANGLE_BITS + FRAC_BITS;
	localparam int FRAME_W    = ANGLE_BITS + 2;

	// filter gain in Q0.16, one extra bit so that unity gain fits
	localparam int ALPHA_FRAC = 16;
	localparam int ALPHA_W    = ALPHA_FRAC + 1;
	localparam int PROD_W     = ALPHA_W + 1 + FX_BITS;

	localparam int RUN_W   = 8;
	localparam int COUNT_W = 32;

	// result word layout
	localparam int OUT_FIELDS_W = FX_BITS + ANGLE_BITS + 1 + 3 * COUNT_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef enum logic [1:0] {
		REG_FILTER_ALPHA   = 2'd0,
		REG_JUMP_THRESHOLD = 2'd1,
		REG_SPIKE_LIMIT    = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		STATUS_ACCEPTED = 2'd0,
		STATUS_PARITY   = 2'd1,
		STATUS_SPIKE    = 2'd2
	} frame_status_t;

	localparam logic [ALPHA_W-1:0]    ALPHA_RESET     = ALPHA_W'(1 << ALPHA_FRAC);
	localparam logic [ANGLE_BITS-1:0] THRESHOLD_RESET = ANGLE_BITS'(1 << (ANGLE_BITS - 1));
	localparam logic [RUN_W-1:0]      SPIKE_LIM_RESET = RUN_W'(3);

endpackage

`default_nettype wire

// ----- sv/encoder_angle_conditioner_unit.sv -----
// encoder angle conditioner: parity check, spike rejection and iir angle filter
`default_nettype none

// Takes one raw sensor frame per transaction and returns one result per frame.
// A frame is captured in an input register, then parity check, wrap-aware
// jump test, spike run counting, the filter multiply (17 x 24 bits) and the
// modular update all resolve combinationally into the result register and the
// filter state, so a new frame is taken every clock while the result register
// is free or drains; a frame moves from the input to the result register. The
// multiply-add feeding the filter state is the critical path. tready on the
// input stays high while the result register drains or is free. Configuration
// registers (gain at 0x0, jump threshold at 0x4, spike limit at 0x8) must be
// written only while no frame is in flight.
module encoder_angle_conditioner_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// slave stream: [15:0] frame
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [eac_pkg::FRAME_W-1:0]       s_tdata,
	// master stream: [23:0] filtered_angle, [37:24] raw_angle, [38] magnet_flag,
	// [70:39] accepted_count, [102:71] parity_error_count,
	// [134:103] spike_rejects, [135] zero
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [eac_pkg::OUT_DATA_W-1:0]         m_tdata,
	// [1:0] frame_status
	output logic [1:0]                             m_tuser,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [eac_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [eac_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [eac_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready
);
	import eac_pkg::*;

	// configuration registers
	logic [ALPHA_W-1:0]    alpha_q;
	logic [ANGLE_BITS-1:0] threshold_q;
	logic [RUN_W-1:0]      spike_limit_q;

	// input register
	logic                  valid_s1;
	logic [FRAME_W-1:0]    frame_s1;

	// filter state
	logic                  seeded_q;
	logic [ANGLE_BITS-1:0] last_raw_q;
	logic [FX_BITS-1:0]    filter_q;
	logic [RUN_W-1:0]      spike_run_q;
	logic                  magnet_q;
	logic [ANGLE_BITS-1:0] valid_raw_q;
	logic [COUNT_W-1:0]    accepted_q;
	logic [COUNT_W-1:0]    parity_q;
	logic [COUNT_W-1:0]    spike_q;

	// result register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	frame_status_t         out_status_q;

	logic                  advance;
	reg_index_t            wr_index;
	logic                  cfg_write;

	// apb decode
	assign pready    = 1'b1;
	assign cfg_write = psel & penable & pwrite & pready;
	assign wr_index  = reg_index_t'(paddr[3:2]);

	always_comb begin
		case (wr_index)
			REG_FILTER_ALPHA:   prdata = APB_DATA_W'(alpha_q);
			REG_JUMP_THRESHOLD: prdata = APB_DATA_W'(threshold_q);
			REG_SPIKE_LIMIT:    prdata = APB_DATA_W'(spike_limit_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q       <= ALPHA_RESET;
			threshold_q   <= THRESHOLD_RESET;
			spike_limit_q <= SPIKE_LIM_RESET;
		end else if (cfg_write) begin
			case (wr_index)
				REG_FILTER_ALPHA:   alpha_q       <= pwdata[ALPHA_W-1:0];
				REG_JUMP_THRESHOLD: threshold_q   <= pwdata[ANGLE_BITS-1:0];
				REG_SPIKE_LIMIT:    spike_limit_q <= pwdata[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: the input register moves on whenever the result register is free or drains
	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			frame_s1 <= s_tdata;
		end
	end

	// frame decode and seeding
	logic                     parity_ok;
	logic [ANGLE_BITS-1:0]    raw;
	logic [ANGLE_BITS-1:0]    ref_raw;
	logic [FX_BITS-1:0]       raw_fx;
	logic [FX_BITS-1:0]       filt_cur;
	logic [RUN_W-1:0]         run_cur;

	assign parity_ok = ~(^frame_s1);
	assign raw       = frame_s1[FRAME_W-1:2];
	assign raw_fx    = {raw, {FRAC_BITS{1'b0}}};
	assign ref_raw   = seeded_q ? last_raw_q  : raw;
	assign filt_cur  = seeded_q ? filter_q    : raw_fx;
	assign run_cur   = seeded_q ? spike_run_q : '0;

	// wrap-aware jump test and spike run
	logic [ANGLE_BITS-1:0]    jump;
	logic [ANGLE_BITS-1:0]    jump_mag;
	logic                     big_jump;
	logic [RUN_W-1:0]         run_inc;
	logic                     reject;
	logic [RUN_W-1:0]         run_next;

	assign jump     = raw - ref_raw;
	assign jump_mag = jump[ANGLE_BITS-1] ? (~jump + 1'b1) : jump;
	assign big_jump = jump_mag > threshold_q;
	assign run_inc  = run_cur + 1'b1;
	assign reject   = big_jump & (run_inc < spike_limit_q);
	assign run_next = reject ? run_inc : '0;

	// filter step: round(alpha * wrapped difference), ties upward
	logic signed [FX_BITS-1:0] fdiff;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  rounded;
	logic [FX_BITS-1:0]        step;
	logic [FX_BITS-1:0]        filt_next;

	assign fdiff     = $signed(raw_fx - filt_cur);
	assign prod      = $signed({1'b0, alpha_q}) * fdiff;
	assign rounded   = prod + PROD_W'(1 << (ALPHA_FRAC - 1));
	assign step      = rounded[FX_BITS+ALPHA_FRAC-1:ALPHA_FRAC];
	assign filt_next = filt_cur + step;

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q    <= 1'b0;
			last_raw_q  <= '0;
			filter_q    <= '0;
			spike_run_q <= '0;
			magnet_q    <= 1'b0;
			valid_raw_q <= '0;
			accepted_q  <= '0;
			parity_q    <= '0;
			spike_q     <= '0;
		end else if (advance) begin
			if (!parity_ok) begin
				parity_q <= parity_q + 1'b1;
			end else begin
				seeded_q    <= 1'b1;
				valid_raw_q <= raw;
				magnet_q    <= frame_s1[1];
				spike_run_q <= run_next;
				if (reject) begin
					spike_q    <= spike_q + 1'b1;
					last_raw_q <= ref_raw;
					filter_q   <= filt_cur;
				end else begin
					last_raw_q <= raw;
					filter_q   <= filt_next;
					accepted_q <= accepted_q + 1'b1;
				end
			end
		end
	end

	// result values as they stand after this frame
	logic [FX_BITS-1:0]    res_filter;
	logic [ANGLE_BITS-1:0] res_raw;
	logic                  res_magnet;
	logic [COUNT_W-1:0]    res_acc;
	logic [COUNT_W-1:0]    res_par;
	logic [COUNT_W-1:0]    res_spk;
	frame_status_t         res_status;

	always_comb begin
		res_filter = filter_q;
		res_raw    = valid_raw_q;
		res_magnet = magnet_q;
		res_acc    = accepted_q;
		res_par    = parity_q;
		res_spk    = spike_q;
		res_status = STATUS_ACCEPTED;
		if (!parity_ok) begin
			res_par    = parity_q + 1'b1;
			res_status = STATUS_PARITY;
		end else begin
			res_raw    = raw;
			res_magnet = frame_s1[1];
			if (reject) begin
				res_filter = filt_cur;
				res_spk    = spike_q + 1'b1;
				res_status = STATUS_SPIKE;
			end else begin
				res_filter = filt_next;
				res_acc    = accepted_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q   <= OUT_DATA_W'({res_spk, res_par, res_acc, res_magnet,
				res_raw, res_filter});
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// an item held in the input register stays while the result side is stalled
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(frame_s1)))
		else $error("input register lost or changed a stalled frame");

	// exactly one of the three counters moves per processed frame
	a_one_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> ($countones({accepted_q != $past(accepted_q),
			parity_q != $past(parity_q), spike_q != $past(spike_q)}) == 1))
		else $error("frame counters did not move exactly once");

	// a spike rejection leaves the filter untouched
	a_spike_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && parity_ok && reject) |=> $stable(filter_q))
		else $error("filter moved on a rejected spike");

	// the result status never takes the unused code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STATUS_ACCEPTED || m_tuser == STATUS_PARITY
			|| m_tuser == STATUS_SPIKE))
		else $error("result carries an undefined frame status");

endmodule

`default_nettype wire
